// ----- rtl/shadow_atlas_planner_defines.svh -----
// ----------------------------------------------------------------------------
// shadow atlas planner assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SHADOW_ATLAS_PLANNER_DEFINES_SVH
`define SHADOW_ATLAS_PLANNER_DEFINES_SVH

// same-cycle implication
`define SAP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sap assertion failed");

// next-cycle implication
`define SAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sap assertion failed");

`endif

// ----- rtl/sap_pkg.sv -----
// ----------------------------------------------------------------------------
// sap_pkg
// types, constants and small lookup functions of the shadow atlas planner
// ----------------------------------------------------------------------------
package sap_pkg;

    localparam logic [15:0] LIMIT_DEFAULT = 16'd8192;
    localparam logic [22:0] MIN_SIDE      = 23'd512;

    localparam logic REG_ATLAS_DIM_LIMIT = 1'b0;
    localparam logic REG_TILE_PADDING    = 1'b1;

    typedef struct packed {
        logic [15:0] limit;
        logic [10:0] pad2;
    } t_cfg;

    typedef struct packed {
        logic [15:0] req;
        logic [7:0]  cnt;
        logic [4:0]  cols;
        logic [4:0]  rows;
        logic        fb;
        logic        over;
        logic [15:0] quo;
        logic [15:0] res;
        logic        clamped;
    } t_plan;

    typedef struct packed {
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] res;
        logic        clamped;
    } t_out;

    // smallest c with c*c >= n
    function automatic logic [4:0] f_cols(input logic [7:0] n);
        logic [4:0] c;
        c = 5'd16;
        for (int k = 15; k >= 1; k--) begin
            if (16'(k * k) >= {8'd0, n}) begin
                c = 5'(k);
            end
        end
        return c;
    endfunction

    // smallest r with r*cols >= n
    function automatic logic [4:0] f_rows(input logic [7:0] n, input logic [4:0] cols);
        logic [4:0] r;
        logic [9:0] p;
        r = 5'd16;
        for (int k = 16; k >= 1; k--) begin
            p = 10'(k) * {5'd0, cols};
            if (p >= {2'd0, n}) begin
                r = 5'(k);
            end
        end
        return r;
    endfunction

    // floor(2^16 / c)
    function automatic logic [16:0] f_recip(input logic [4:0] c);
        logic [16:0] r;
        case (c)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21845;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13107;
            5'd6:    r = 17'd10922;
            5'd7:    r = 17'd9362;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7281;
            5'd10:   r = 17'd6553;
            5'd11:   r = 17'd5957;
            5'd12:   r = 17'd5461;
            5'd13:   r = 17'd5041;
            5'd14:   r = 17'd4681;
            5'd15:   r = 17'd4369;
            5'd16:   r = 17'd4096;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic [16:0] f_p2floor(input logic [16:0] v);
        logic [16:0] p;
        p = '0;
        for (int k = 0; k < 17; k++) begin
            if (v[k]) begin
                p = 17'(1) << k;
            end
        end
        return p;
    endfunction

    // next power of two of max(v, 512)
    function automatic logic [22:0] f_p2ceil(input logic [21:0] v);
        logic [21:0] m;
        logic [22:0] p;
        m = v - 22'd1;
        p = '0;
        for (int k = 0; k < 22; k++) begin
            if (m[k]) begin
                p = 23'(1) << (k + 1);
            end
        end
        if ({1'b0, v} <= MIN_SIDE) begin
            p = MIN_SIDE;
        end
        return p;
    endfunction

endpackage

// ----- rtl/sap_grid.sv -----
// ----------------------------------------------------------------------------
// sap_grid
// two stages: grid shape lookup, then padded grid size against the limit
// ----------------------------------------------------------------------------
module sap_grid import sap_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_plan i_plan,
    output logic  o_valid,
    input  logic  i_ready,
    output t_plan o_plan
);

    logic [1:0] r_vld;
    logic [1:0] w_en;
    t_plan      r_p0, r_p1;
    t_plan      n_p0, n_p1;
    logic [16:0] w_tile;
    logic [21:0] w_pw, w_ph;

    always_comb begin
        w_en[1] = !r_vld[1] || i_ready;
        w_en[0] = !r_vld[0] || w_en[1];
    end

    always_comb begin
        n_p0      = i_plan;
        n_p0.cols = f_cols(i_plan.cnt);
        n_p0.rows = f_rows(i_plan.cnt, n_p0.cols);
        n_p0.fb   = (i_plan.cnt == 8'd0) || (i_plan.req == 16'd0);
    end

    always_comb begin
        w_tile    = {1'b0, r_p0.req} + {6'd0, i_cfg.pad2};
        w_pw      = {17'd0, r_p0.cols} * {5'd0, w_tile};
        w_ph      = {17'd0, r_p0.rows} * {5'd0, w_tile};
        n_p1      = r_p0;
        n_p1.over = (w_pw > {6'd0, i_cfg.limit}) || (w_ph > {6'd0, i_cfg.limit});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_p0 <= n_p0;
        if (w_en[1]) r_p1 <= n_p1;
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[1];
    assign o_plan  = r_p1;

endmodule

// ----- rtl/sap_clamp.sv -----
// ----------------------------------------------------------------------------
// sap_clamp
// three stages: limit / cols by reciprocal, remainder fix-up, power-of-two clamp
// ----------------------------------------------------------------------------
module sap_clamp import sap_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_plan i_plan,
    output logic  o_valid,
    input  logic  i_ready,
    output t_plan o_plan
);

    logic [2:0]  r_vld;
    logic [2:0]  w_en;
    t_plan       r_p0, r_p1, r_p2;
    t_plan       n_p0, n_p1, n_p2;
    logic [32:0] w_prod;
    logic [20:0] w_qm;
    logic [20:0] w_rem;
    logic [16:0] w_fit;

    always_comb begin
        w_en[2] = !r_vld[2] || i_ready;
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    // rows never exceed cols, so min(limit/cols, limit/rows) is limit/cols
    always_comb begin
        w_prod   = {17'd0, i_cfg.limit} * {16'd0, f_recip(i_plan.cols)};
        n_p0     = i_plan;
        n_p0.quo = w_prod[31:16];
    end

    // estimate is low by at most one
    always_comb begin
        w_qm  = {5'd0, r_p0.quo} * {16'd0, r_p0.cols};
        w_rem = {5'd0, i_cfg.limit} - w_qm;
        n_p1  = r_p0;
        if (w_rem >= {16'd0, r_p0.cols}) begin
            n_p1.quo = r_p0.quo + 16'd1;
        end
    end

    always_comb begin
        w_fit        = f_p2floor({1'b0, r_p1.quo} - {6'd0, i_cfg.pad2});
        n_p2         = r_p1;
        n_p2.res     = r_p1.req;
        n_p2.clamped = 1'b0;
        if (r_p1.over && ({1'b0, r_p1.quo} > {6'd0, i_cfg.pad2})) begin
            if (w_fit < {1'b0, r_p1.req}) begin
                n_p2.res     = w_fit[15:0];
                n_p2.clamped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_p0 <= n_p0;
        if (w_en[1]) r_p1 <= n_p1;
        if (w_en[2]) r_p2 <= n_p2;
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[2];
    assign o_plan  = r_p2;

endmodule

// ----- rtl/sap_size.sv -----
// ----------------------------------------------------------------------------
// sap_size
// two stages: final grid size, then power-of-two sides capped at the limit
// ----------------------------------------------------------------------------
module sap_size import sap_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_plan i_plan,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_out
);

    logic [1:0]  r_vld;
    logic [1:0]  w_en;
    t_plan       r_p0;
    logic [21:0] r_pw, r_ph;
    logic [21:0] n_pw, n_ph;
    t_out        r_out, n_out;
    logic [16:0] w_tile;
    logic [22:0] w_w, w_h;
    logic [15:0] w_side;

    always_comb begin
        w_en[1] = !r_vld[1] || i_ready;
        w_en[0] = !r_vld[0] || w_en[1];
    end

    always_comb begin
        w_tile = {1'b0, i_plan.res} + {6'd0, i_cfg.pad2};
        n_pw   = {17'd0, i_plan.cols} * {5'd0, w_tile};
        n_ph   = {17'd0, i_plan.rows} * {5'd0, w_tile};
    end

    always_comb begin
        w_w    = f_p2ceil(r_pw);
        w_h    = f_p2ceil(r_ph);
        w_side = (i_cfg.limit < MIN_SIDE[15:0]) ? i_cfg.limit : MIN_SIDE[15:0];
        n_out.width   = (w_w < {7'd0, i_cfg.limit}) ? w_w[15:0] : i_cfg.limit;
        n_out.height  = (w_h < {7'd0, i_cfg.limit}) ? w_h[15:0] : i_cfg.limit;
        n_out.res     = r_p0.res;
        n_out.clamped = r_p0.clamped;
        // empty request gets a square fallback
        if (r_p0.fb) begin
            n_out.width   = w_side;
            n_out.height  = w_side;
            n_out.res     = 16'd0;
            n_out.clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p0 <= i_plan;
            r_pw <= n_pw;
            r_ph <= n_ph;
        end
        if (w_en[1]) r_out <= n_out;
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[1];
    assign o_out   = r_out;

endmodule

// ----- rtl/shadow_atlas_planner.sv -----
// ----------------------------------------------------------------------------
// shadow_atlas_planner
// plans a shadow atlas grid for a set of cascades, one plan per cycle unless m_axis stalls
//
//   channel   dir  fields (lowest bit up)
//   s_axis    in   tdata: requested_resolution[15:0], cascade_count[23:16]
//   m_axis    out  tdata: atlas_width, atlas_height, granted_resolution, clamped
//   cfg       in   idx 0 atlas_dim_limit, idx 1 tile_padding
//
// seven register stages from s_axis to m_axis, one item per cycle while m_axis is not stalled
// synchronous active-low reset clears the valid bits and the config registers
// a stall at m_axis fills the empty stages first, then holds s_axis_tready low
// ----------------------------------------------------------------------------
`include "shadow_atlas_planner_defines.svh"

module shadow_atlas_planner import sap_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // requested_resolution, cascade_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // atlas_width, atlas_height, granted_resolution, clamped
);

    logic [15:0] r_limit_raw;
    logic [9:0]  r_pad;
    t_cfg        w_cfg;
    t_plan       w_in;
    logic        w_g_valid, w_g_ready, w_c_valid, w_c_ready;
    t_plan       w_g_plan, w_c_plan;
    t_out        w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_raw <= '0;
            r_pad       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ATLAS_DIM_LIMIT: r_limit_raw <= i_cfg_data;
                REG_TILE_PADDING:    r_pad       <= i_cfg_data[9:0];
                default:             r_pad       <= r_pad;
            endcase
        end
    end

    always_comb begin
        w_cfg.limit = (r_limit_raw == 16'd0) ? LIMIT_DEFAULT : r_limit_raw;
        w_cfg.pad2  = {r_pad, 1'b0};
        w_in        = '0;
        w_in.req    = s_axis_tdata[15:0];
        w_in.cnt    = s_axis_tdata[23:16];
    end

    sap_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_plan  (w_in),
        .o_valid (w_g_valid),
        .i_ready (w_g_ready),
        .o_plan  (w_g_plan)
    );

    sap_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_g_valid),
        .o_ready (w_g_ready),
        .i_plan  (w_g_plan),
        .o_valid (w_c_valid),
        .i_ready (w_c_ready),
        .o_plan  (w_c_plan)
    );

    sap_size u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_plan  (w_c_plan),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_out   (w_out)
    );

    assign m_axis_tdata = {7'd0, w_out.clamped, w_out.res, w_out.height, w_out.width};

    `SAP_ASSERT_NOW(a_clamp_pow2, m_axis_tvalid && w_out.clamped, $onehot(w_out.res))
    `SAP_ASSERT_NOW(a_side_cap, m_axis_tvalid, (w_out.width <= w_cfg.limit) && (w_out.height <= w_cfg.limit))
    `SAP_ASSERT_NOW(a_full_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

// ----- tb/sv/shadow_atlas_planner_tb.sv -----
// ----------------------------------------------------------------------------
// shadow_atlas_planner_tb
// drives atlas plan requests with random gaps and back-pressure under several
// limit and padding settings, predicts each plan and checks results in order
// ----------------------------------------------------------------------------
module shadow_atlas_planner_tb import sap_pkg::*;;

    typedef struct {
        logic [15:0] req;
        logic [7:0]  cnt;
    } t_request;

    typedef struct {
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] res;
        logic        clamped;
    } t_plan_exp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // requested_resolution, cascade_count
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // atlas_width, atlas_height, granted_resolution, clamped

    shadow_atlas_planner u_top (.*);

    t_request   pending_q[$];
    t_plan_exp  plan_q[$];
    logic [15:0] cur_limit;
    logic [9:0]  cur_pad;
    int          err_cnt;
    int          cycle_cnt;
    int          src_gap;
    int          sink_gap;
    bit          src_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned p2_ceil(longint unsigned v);
        longint unsigned p;
        p = 1;
        while (p < v) p = p << 1;
        return p;
    endfunction

    function automatic longint unsigned p2_floor(longint unsigned v);
        longint unsigned p;
        p = 1;
        if (v == 0) return 0;
        while ((p << 1) <= v) p = p << 1;
        return p;
    endfunction

    function automatic t_plan_exp plan_atlas(t_request r);
        t_plan_exp e;
        longint unsigned lim, pad2, cols, rows, res, tile, fit, wn, hn, w, h;
        lim  = (cur_limit != 0) ? cur_limit : LIMIT_DEFAULT;
        pad2 = 2 * cur_pad;
        e.clamped = 1'b0;
        if (r.cnt == 0 || r.req == 0) begin
            w = (lim < 512) ? lim : 512;
            e.width = w[15:0];
            e.height = w[15:0];
            e.res = '0;
            return e;
        end
        cols = 1;
        while (cols * cols < r.cnt) cols++;
        rows = (r.cnt + cols - 1) / cols;
        res = r.req;
        if (cols * (res + pad2) > lim || rows * (res + pad2) > lim) begin
            tile = (lim / cols < lim / rows) ? lim / cols : lim / rows;
            if (tile > pad2) begin
                fit = p2_floor(tile - pad2);
                if (fit > 0) begin
                    res = (r.req < fit) ? r.req : fit;
                    e.clamped = (res != r.req);
                end
            end
        end
        wn = cols * (res + pad2);
        hn = rows * (res + pad2);
        w = p2_ceil(wn > 512 ? wn : 512);
        h = p2_ceil(hn > 512 ? hn : 512);
        if (w > lim) w = lim;
        if (h > lim) h = lim;
        e.width = w[15:0];
        e.height = h[15:0];
        e.res = res[15:0];
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver: one item per handshake, random gaps between items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) plan_q.push_back(plan_atlas('{s_axis_tdata[15:0], s_axis_tdata[23:16]}));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0 && !src_hold) begin
                t_request r;
                r = pending_q.pop_front();
                s_axis_tdata <= {r.cnt, r.req};
                s_axis_tvalid <= 1'b1;
                src_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random stalls, compare against the oldest expected plan
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (plan_q.size() == 0) begin
                    $display("unexpected result at cycle %0d", cycle_cnt);
                    err_cnt++;
                end else begin
                    t_plan_exp e;
                    e = plan_q.pop_front();
                    if (m_axis_tdata[15:0] !== e.width)
                        report_mismatch("atlas_width", m_axis_tdata[15:0], e.width);
                    if (m_axis_tdata[31:16] !== e.height)
                        report_mismatch("atlas_height", m_axis_tdata[31:16], e.height);
                    if (m_axis_tdata[47:32] !== e.res)
                        report_mismatch("granted_resolution", m_axis_tdata[47:32], e.res);
                    if (m_axis_tdata[48] !== e.clamped)
                        report_mismatch("clamped", {15'd0, m_axis_tdata[48]}, {15'd0, e.clamped});
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_item(logic [15:0] req, logic [7:0] cnt);
        pending_q.push_back('{req, cnt});
    endtask

    // waits until every expected plan is back and the pipe has drained
    task automatic wait_idle();
        while (pending_q.size() > 0 || s_axis_tvalid || plan_q.size() > 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_ATLAS_DIM_LIMIT) cur_limit = val;
        else cur_pad = val[9:0];
    endtask

    function automatic logic [15:0] rand_req();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'($urandom_range(0, 65535));
        if (k < 3) return 16'(1 << $urandom_range(0, 15));
        return 16'($urandom_range(1, 4096));
    endfunction

    logic [15:0] limits[8] = '{16'd0, 16'd65535, 16'd1, 16'd512, 16'd8192, 16'd1000,
                               16'd300, 16'd16384};
    logic [9:0]  pads[8]   = '{10'd0, 10'd1023, 10'd0, 10'd3, 10'd8, 10'd100,
                               10'd40, 10'd512};

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cur_limit = '0;
        cur_pad = '0;
        err_cnt = 0;
        cycle_cnt = 0;
        src_hold = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty requests, field extremes, overflow and no-fit cases
        add_item(16'd0, 8'd0);
        add_item(16'd0, 8'd4);
        add_item(16'd1024, 8'd0);
        add_item(16'd1, 8'd1);
        add_item(16'd65535, 8'd255);
        add_item(16'd65535, 8'd1);
        add_item(16'd1, 8'd255);
        add_item(16'd2048, 8'd4);
        add_item(16'd4096, 8'd5);
        add_item(16'd5000, 8'd9);
        add_item(16'd256, 8'd2);
        add_item(16'd32768, 8'd128);
        add_item(16'd21845, 8'd170);
        wait_idle();
        write_reg(REG_TILE_PADDING, 16'd1023);
        add_item(16'd512, 8'd4);
        add_item(16'd1, 8'd1);
        add_item(16'd0, 8'd7);
        wait_idle();
        write_reg(REG_ATLAS_DIM_LIMIT, 16'd100);
        add_item(16'd50, 8'd3);
        add_item(16'd0, 8'd0);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_ATLAS_DIM_LIMIT, limits[ph]);
            write_reg(REG_TILE_PADDING, {6'd0, pads[ph]});
            for (int i = 0; i < 210; i++) begin
                logic [7:0] c;
                c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(1, 16));
                add_item(($urandom_range(0, 30) == 0) ? 16'd0 : rand_req(), c);
                // one pause until everything is back
                if (ph == 3 && i == 100) begin
                    while (pending_q.size() > 0) @(posedge i_clk);
                    src_hold = 1'b1;
                    while (s_axis_tvalid || plan_q.size() > 0) @(posedge i_clk);
                    src_hold = 1'b0;
                end
            end
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
